// ===== rtl/pltsc_pkg.sv =====
// Shared types and constants for the pitch/level to shimmer color block.
package pltsc_pkg;

  localparam int unsigned LogW  = 20;   // log2 result: 4 integer bits, 16 fraction bits
  localparam int unsigned DvdW  = 37;   // divider dividend width
  localparam int unsigned DvsW  = 20;   // divider divisor width
  localparam int unsigned QuoW  = 17;   // divider quotient width

  localparam logic [11:0]        DefMinHz   = 12'd100;
  localparam logic [11:0]        DefMaxHz   = 12'd1000;
  localparam logic signed [15:0] DefFloorDb = -16'sd9728;
  localparam logic signed [15:0] DefCeilDb  = -16'sd5120;
  localparam logic [7:0]         DefBright  = 8'd255;
  localparam logic [20:0]        QtoneUpQ20 = 21'd1063828;
  localparam logic [20:0]        QtoneDnQ20 = 21'd1033543;
  localparam int unsigned        DefRefreshMs = 300;

  typedef enum logic [2:0] {
    CFG_RANGE_MIN  = 3'd0,
    CFG_RANGE_MAX  = 3'd1,
    CFG_BRIGHT_MIN = 3'd2,
    CFG_BRIGHT_MAX = 3'd3,
    CFG_FLOOR      = 3'd4,
    CFG_CEILING    = 3'd5,
    CFG_HUE_LOW    = 3'd6,
    CFG_HUE_HIGH   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOG_LO,
    ST_LOG_HI,
    ST_LOG_P,
    ST_DIV_S,
    ST_HUE,
    ST_BRT1,
    ST_BRT2,
    ST_DIV_B,
    ST_FIN
  } seq_state_e;

endpackage

// ===== rtl/pltsc_log2.sv =====
// Iterative log2 unit: Q16 result, one mantissa squaring per cycle.
module pltsc_log2 import pltsc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [15:0]     x_i,
  output logic            done_o,
  output logic [LogW-1:0] result_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [3:0]  cnt_q, cnt_d, n_q, n_d, n_c;
  logic [30:0] m_q, m_d;
  logic [15:0] frac_q, frac_d;
  logic [61:0] sq;
  logic [31:0] sh;

  always_comb begin
    n_c = '0;
    for (int i = 1; i < 16; i++) begin
      if (x_i[i]) n_c = 4'(i);
    end
  end

  assign sq = m_q * m_q;
  assign sh = sq[61:30];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    m_d    = m_q;
    frac_d = frac_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = n_c;
      m_d    = 31'({15'b0, x_i} << (5'd30 - {1'b0, n_c}));
      frac_d = '0;
    end else if (busy_q) begin
      if (sh[31]) begin
        m_d    = sh[31:1];
        frac_d = {frac_q[14:0], 1'b1};
      end else begin
        m_d    = sh[30:0];
        frac_d = {frac_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    m_q    <= m_d;
    frac_q <= frac_d;
  end

  assign done_o   = done_q;
  assign result_o = {n_q, frac_q};

endmodule

// ===== rtl/pltsc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pltsc_div import pltsc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [QuoW-1:0] quotient_o
);

  logic            busy_q, busy_d, done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [DvdW-1:0] rem_q, rem_d, trial;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [QuoW-1:0] quo_q, quo_d;

  assign trial = DvdW'(dvs_q) << cnt_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(QuoW - 1);
      rem_d  = dividend_i;
      dvs_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        quo_d[cnt_q] = 1'b1;
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/pitch_level_to_shimmer_color.sv =====
// Top level: pitch and level to shimmer color sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | pitch_hz_i, level_db_i, time_ms_i
//  out     | source    | out_valid_o / out_stall_i | hue_o, saturation_o, brightness_o,
//          |           |                        | shimmer_active_o, send_now_o
//  cfg     | sink      | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One transaction at a time; the next is taken only in the idle state. Below
// the floor: back to idle, via the final state when an off color goes out. In
// pitch range: three log2 runs, scale divide, hue step, BRT1, BRT2, brightness
// divide; equal range limits skip the scale divide. Out of range: BRT1, BRT2,
// brightness divide. Ceiling not above floor skips the brightness divide.
// Reset clears config to defaults and the shimmer history. A result that is
// stalled holds the sequencer in its final state; input is stalled until then.
module pitch_level_to_shimmer_color import pltsc_pkg::*; #(
  parameter int unsigned REFRESH_INTERVAL_MS = DefRefreshMs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pitch_hz_i,
  input  logic signed [15:0] level_db_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  hue_o,
  output logic [7:0]  saturation_o,
  output logic [7:0]  brightness_o,
  output logic        shimmer_active_o,
  output logic        send_now_o
);

  // configuration
  logic [11:0]        rmin_q, rmax_q;
  logic [7:0]         bmin_q, bmax_q, hlo_q, hhi_q;
  logic signed [15:0] floor_q, ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q  <= '0;
      rmax_q  <= '0;
      bmin_q  <= '0;
      bmax_q  <= DefBright;
      floor_q <= DefFloorDb;
      ceil_q  <= DefCeilDb;
      hlo_q   <= 8'd22;
      hhi_q   <= 8'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RANGE_MIN:  rmin_q  <= cfg_data_i[11:0];
        CFG_RANGE_MAX:  rmax_q  <= cfg_data_i[11:0];
        CFG_BRIGHT_MIN: bmin_q  <= cfg_data_i[7:0];
        CFG_BRIGHT_MAX: bmax_q  <= cfg_data_i[7:0];
        CFG_FLOOR:      floor_q <= cfg_data_i;
        CFG_CEILING:    ceil_q  <= cfg_data_i;
        CFG_HUE_LOW:    hlo_q   <= cfg_data_i[7:0];
        CFG_HUE_HIGH:   hhi_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective settings (zero picks the built-in default)
  logic [15:0]        lo16, hi16;
  logic [7:0]         vmax;
  logic signed [15:0] fl, ce;
  assign lo16 = {(rmin_q == '0) ? DefMinHz : rmin_q, 4'b0};
  assign hi16 = {(rmax_q == '0) ? DefMaxHz : rmax_q, 4'b0};
  assign vmax = (bmax_q == '0) ? DefBright : bmax_q;
  assign fl   = (floor_q == '0) ? DefFloorDb : floor_q;
  assign ce   = (ceil_q == '0) ? DefCeilDb : ceil_q;

  seq_state_e state_q, state_d;

  // transaction and history registers
  logic [15:0]        p_q, prev_q;
  logic signed [15:0] db_q;
  logic [31:0]        now_q, last_t_q;
  logic               on_q, off_q, sendp_q;
  logic [7:0]         last_b_q, held_sat_q, hue_q, sat_q, val_q;
  logic [LogW-1:0]    llo_q, lhi_q;
  logic [16:0]        s_q;
  logic signed [25:0] num_q;

  logic               out_valid_q, out_act_q, out_send_q;
  logic [7:0]         out_hue_q, out_sat_q, out_bri_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // shared units
  logic            log_start, log_done, div_start, div_done;
  logic [15:0]     log_x;
  logic [LogW-1:0] log_res, den_s;
  logic [DvdW-1:0] div_dvd;
  logic [DvsW-1:0] div_dvs;
  logic [QuoW-1:0] div_quo;

  pltsc_log2 u_log2 (
    .clk_i, .rst_ni,
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .result_o(log_res)
  );

  pltsc_div u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // combinational datapath pieces
  logic               below, in_rng;
  logic [35:0]        pa;
  logic [36:0]        pu, pd;
  logic signed [15:0] r;
  logic signed [16:0] denb;
  logic signed [27:0] qb;
  logic signed [27:0] t;
  logic [25:0]        satf;
  logic [31:0]        elapsed;
  logic [7:0]         diff;
  logic [11:0]        diff10;
  logic [7:0]         dn;
  logic               refresh, volc, send;

  assign below  = db_q < fl;
  assign in_rng = (p_q >= lo16) && (p_q <= hi16);
  assign pa     = {p_q, 20'b0};
  assign pu     = prev_q * QtoneUpQ20;
  assign pd     = prev_q * QtoneDnQ20;
  assign den_s  = lhi_q - llo_q;

  assign r    = (db_q > ce) ? ce : db_q;
  assign denb = 17'(ce) - 17'(fl);
  // 2*(vmin*den + num) + den, rounding term folded in
  assign qb   = 28'sd2 * (28'($signed({1'b0, bmin_q})) * 28'(denb) + 28'(num_q)) + 28'(denb);

  assign t    = 28'($signed({1'b0, hlo_q, 16'b0}))
              + 28'($signed({1'b0, hhi_q}) - $signed({1'b0, hlo_q})) * 28'($signed({1'b0, s_q}));
  assign satf = 26'd255 * (26'h10000 - 26'(s_q)) + 26'd32768;

  assign elapsed = now_q - last_t_q;
  assign diff    = (val_q > last_b_q) ? val_q - last_b_q : last_b_q - val_q;
  assign diff10  = 12'(diff) * 12'd10;
  assign dn      = (last_b_q == '0) ? 8'd1 : last_b_q;
  assign refresh = (val_q == last_b_q) && (elapsed >= 32'(REFRESH_INTERVAL_MS));
  assign volc    = diff10 > 12'(dn);
  assign send    = sendp_q || refresh || volc;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_EVAL;
      ST_EVAL: begin
        if (below)       state_d = on_q ? ST_FIN : ST_IDLE;
        else if (in_rng) state_d = ST_LOG_LO;
        else             state_d = ST_BRT1;
      end
      ST_LOG_LO: if (log_done) state_d = ST_LOG_HI;
      ST_LOG_HI: if (log_done) state_d = ST_LOG_P;
      ST_LOG_P:  if (log_done) state_d = (den_s != '0) ? ST_DIV_S : ST_HUE;
      ST_DIV_S:  if (div_done) state_d = ST_HUE;
      ST_HUE:    state_d = ST_BRT1;
      ST_BRT1:   state_d = ST_BRT2;
      ST_BRT2:   state_d = (denb > 17'sd0) ? ST_DIV_B : ST_FIN;
      ST_DIV_B:  if (div_done) state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: unit starts and operand selection
  always_comb begin
    log_start = (state_d != state_q) &&
                (state_d == ST_LOG_LO || state_d == ST_LOG_HI || state_d == ST_LOG_P);
    div_start = (state_d != state_q) && (state_d == ST_DIV_S || state_d == ST_DIV_B);
    log_x     = p_q;
    if (state_d == ST_LOG_LO)      log_x = lo16;
    else if (state_d == ST_LOG_HI) log_x = hi16;
    if (state_d == ST_DIV_S) begin
      div_dvd = DvdW'({log_res - llo_q, 16'b0});
      div_dvs = den_s;
    end else begin
      div_dvd = (qb < 28'sd0) ? '0 : DvdW'(qb[26:0]);
      div_dvs = DvsW'({denb[15:0], 1'b0}) | DvsW'({denb[16], 17'b0});
    end
    in_stall_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      on_q        <= 1'b0;
      prev_q      <= '0;
      last_b_q    <= 8'd255;
      last_t_q    <= '0;
      held_sat_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
        if (off_q) begin
          on_q     <= 1'b0;
          last_b_q <= '0;
          last_t_q <= now_q;
        end else begin
          on_q       <= 1'b1;
          prev_q     <= p_q;
          held_sat_q <= sat_q;
          if (send) begin
            last_b_q <= val_q;
            last_t_q <= now_q;
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_q   <= pitch_hz_i;
      db_q  <= level_db_i;
      now_q <= time_ms_i;
    end
    unique case (state_q)
      ST_EVAL: begin
        off_q   <= below;
        sendp_q <= (prev_q == '0) || (p_q == '0) || ({1'b0, pa} > pu) || ({1'b0, pa} < pd);
        s_q     <= '0;
        if (p_q > hi16) begin
          hue_q <= hhi_q;
          sat_q <= '0;
        end else begin
          hue_q <= hlo_q;
          sat_q <= 8'd255;
        end
      end
      ST_LOG_LO: if (log_done) llo_q <= log_res;
      ST_LOG_HI: if (log_done) lhi_q <= log_res;
      ST_DIV_S:  if (div_done) s_q <= (div_quo > 17'h10000) ? 17'h10000 : div_quo;
      ST_HUE: begin
        hue_q <= (t < 28'sd0) ? 8'd0 : t[23:16];
        sat_q <= satf[23:16];
      end
      ST_BRT1: num_q <= 26'(17'(r) - 17'(fl)) * 26'($signed({1'b0, vmax}) - $signed({1'b0, bmin_q}));
      ST_BRT2: val_q <= bmin_q;
      ST_DIV_B: if (div_done) val_q <= (div_quo > 17'd255) ? 8'd255 : div_quo[7:0];
      ST_FIN: begin
        if (out_free) begin
          if (off_q) begin
            out_hue_q  <= hlo_q;
            out_sat_q  <= held_sat_q;
            out_bri_q  <= '0;
            out_act_q  <= 1'b0;
            out_send_q <= 1'b1;
          end else begin
            out_hue_q  <= hue_q;
            out_sat_q  <= sat_q;
            out_bri_q  <= val_q;
            out_act_q  <= 1'b1;
            out_send_q <= send;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign hue_o            = out_hue_q;
  assign saturation_o     = out_sat_q;
  assign brightness_o     = out_bri_q;
  assign shimmer_active_o = out_act_q;
  assign send_now_o       = out_send_q;

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EVAL) else $error("accepted transaction did not start");
  a_off_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !shimmer_active_o |-> send_now_o && brightness_o == 8'd0)
    else $error("off result malformed");
  a_log_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_done |-> state_q == ST_LOG_LO || state_q == ST_LOG_HI || state_q == ST_LOG_P)
    else $error("log2 finished outside a log state");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_S || state_q == ST_DIV_B)
    else $error("divider finished outside a divide state");

endmodule
